[hdl/alt_pkg.sv]
// Types and constants shared by the address lease table.
// No dependencies; imported by every module of the block.
package alt_pkg;

  localparam int               EXPIRY_W    = 31;
  localparam logic [30:0]      EXPIRY_RST  = 31'd15000;
  localparam int               COUNT_OUT_W = 6;

  typedef enum logic [2:0] {
    OP_ALLOC      = 3'd0,
    OP_ADDR_OF_ID = 3'd1,
    OP_ID_OF_ADDR = 3'd2,
    OP_RENEW      = 3'd3,
    OP_RELEASE    = 3'd4,
    OP_PRUNE      = 3'd5
  } alt_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } alt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } alt_state_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  node_id;
    logic [15:0] address;
    logic [31:0] now_ms;
  } alt_in_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [15:0]            value;
    logic [COUNT_OUT_W-1:0] entry_count;
  } alt_out_t;

  typedef struct packed {
    logic [7:0]  node;
    logic [15:0] address;
    logic [31:0] stamp;
  } alt_entry_t;

endpackage

[hdl/alt_lease_check.sv]
// Expiry test for one table entry during prune.
// Depends on alt_pkg for the expiry width.
module alt_lease_check import alt_pkg::*; (
  input  logic [31:0]         now_i,
  input  logic [31:0]         stamp_i,
  input  logic [EXPIRY_W-1:0] expiry_i,
  output logic                keep_o
);

  logic [31:0] age;
  logic        young;

  // negative age (stamp ahead of now) always counts as young; keep_o also needs stamp below now
  assign age    = now_i - stamp_i;
  assign young  = age[31] | (age[30:0] < expiry_i);
  assign keep_o = young & (stamp_i < now_i);

endmodule

[hdl/address_lease_table.sv]
// Address lease table: top level with sequencer and entry memory.
// Depends on alt_pkg and alt_lease_check.
//
//  channel   | direction | handshake            | beat
//  ----------+-----------+----------------------+-----------------------------
//  in        | input     | in_valid_i/in_stall_o   | alt_in_t  (op, id, addr, now)
//  out       | output    | out_valid_o/out_stall_i | alt_out_t (status, value, count)
//  cfg       | input     | cfg_we_i, no wait       | expiry_ms, 31 bits
//
// Accept to result: one read per valid entry, a drain step for the last read,
// a done step and the finish step, which waits while an earlier result is
// stalled; the next input beat is taken only once the item has finished.
// Reset clears the count and sets expiry_ms to 15000; no clearing pass.
// The result sits in an output register, so a stalled result does not block
// the next input beat; only a second finished result waits for it.
module address_lease_table import alt_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  alt_in_t             in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output alt_out_t            out_beat_o,
  input  logic                cfg_we_i,
  input  logic [EXPIRY_W-1:0] cfg_wdata_i
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // sequencer
  alt_state_e          state_q, state_d;
  alt_in_t             req_q;
  logic [EXPIRY_W-1:0] expiry_q;
  logic [CNT_W-1:0]    count_q;

  // scan pointers: rd_ptr issues reads, wr_ptr is the compaction target
  logic [CNT_W-1:0]    rd_ptr_q, wr_ptr_q;
  logic                rv_q;          // rd_data_q holds a fresh entry
  logic [IDX_W-1:0]    rv_idx_q;      // its index
  alt_entry_t          rd_data_q;

  // first match of the search key
  logic                found_q;
  alt_entry_t          hit_q;
  logic [IDX_W-1:0]    hit_idx_q;

  logic                out_valid_q;
  alt_out_t            out_q, out_d;

  logic                accept, mem_re, scan_done, finish_go;
  logic                key_hit, first_hit, keep, comp_wr;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  alt_entry_t          mem_wdata;
  logic [CNT_W-1:0]    res_count;
  alt_status_e         res_status;
  logic [15:0]         res_value;
  logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

  alt_entry_t mem [CAPACITY];

  // ---------------------------------------------------------------------
  // FSM
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (scan_done) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (finish_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    accept     = in_valid_i && (state_q == S_IDLE);
    mem_re     = (state_q == S_SCAN) && (rd_ptr_q < count_q);
    scan_done  = (state_q == S_SCAN) && !mem_re && !rv_q;
    // finish only once the previous result has left the output register
    finish_go  = (state_q == S_FINISH) && !(out_valid_q && out_stall_i);
  end

  // ---------------------------------------------------------------------
  // Per-entry work on the read data
  // ---------------------------------------------------------------------
  alt_lease_check u_lease_check (
    .now_i    (req_q.now_ms),
    .stamp_i  (rd_data_q.stamp),
    .expiry_i (expiry_q),
    .keep_o   (keep)
  );

  always_comb begin
    key_hit = 1'b0;
    if (req_q.op inside {OP_ALLOC, OP_ADDR_OF_ID, OP_RENEW}) begin
      key_hit = (rd_data_q.node == req_q.node_id);
    end else if (req_q.op inside {OP_ID_OF_ADDR, OP_RELEASE}) begin
      key_hit = (rd_data_q.address == req_q.address);
    end
    first_hit = rv_q && key_hit && !found_q;
    // release drops only the first match; prune drops every entry failing the lease check
    comp_wr = rv_q && (((req_q.op == OP_RELEASE) && !first_hit) ||
                       ((req_q.op == OP_PRUNE) && keep));
  end

  // ---------------------------------------------------------------------
  // Result and final write
  // ---------------------------------------------------------------------
  always_comb begin
    res_count  = count_q;
    res_status = ST_OK;
    res_value  = '0;
    case (req_q.op)
      OP_ALLOC: begin
        if (!found_q) begin
          if (count_q != CAP_CNT) res_count = count_q + 1'b1;
          else                    res_status = ST_FULL;
        end
      end
      OP_ADDR_OF_ID: begin
        if (found_q) res_value = hit_q.address;
        else         res_status = ST_MISSING;
      end
      OP_ID_OF_ADDR: begin
        if (found_q) res_value = {8'b0, hit_q.node};
        else         res_status = ST_MISSING;
      end
      OP_RENEW: begin
        if (!found_q) res_status = ST_MISSING;
      end
      OP_RELEASE: begin
        if (found_q) res_count = count_q - 1'b1;
        else         res_status = ST_MISSING;
      end
      OP_PRUNE: begin
        res_count = wr_ptr_q;
      end
      default: ;
    endcase
    cnt_ext           = {{COUNT_OUT_W{1'b0}}, res_count};
    out_d.status      = res_status;
    out_d.value       = res_value;
    out_d.entry_count = cnt_ext[COUNT_OUT_W-1:0];
  end

  // Write port: compaction during the scan, one update or append at finish.
  // Writes never reach an index at or above the next read, so no forwarding.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_ptr_q[IDX_W-1:0];
    mem_wdata = rd_data_q;
    if ((state_q == S_SCAN) && comp_wr) begin
      mem_we = 1'b1;
    end else if (finish_go) begin
      case (req_q.op)
        OP_ALLOC: begin
          mem_wdata = '{node: req_q.node_id, address: req_q.address,
                        stamp: req_q.now_ms};
          if (found_q) begin
            mem_we    = 1'b1;
            mem_waddr = hit_idx_q;
          end else if (count_q != CAP_CNT) begin
            mem_we    = 1'b1;
            mem_waddr = count_q[IDX_W-1:0];
          end
        end
        OP_RENEW: begin
          mem_wdata = '{node: hit_q.node, address: hit_q.address,
                        stamp: req_q.now_ms};
          mem_we    = found_q;
          mem_waddr = hit_idx_q;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Entry memory, one write and one registered read port
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_q <= mem[rd_ptr_q[IDX_W-1:0]];
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      expiry_q    <= EXPIRY_RST;
      count_q     <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      rv_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= mem_re;
      if (cfg_we_i) expiry_q <= cfg_wdata_i;
      if (accept) begin
        rd_ptr_q <= '0;
        wr_ptr_q <= '0;
        found_q  <= 1'b0;
      end else begin
        if (mem_re)    rd_ptr_q <= rd_ptr_q + 1'b1;
        if (comp_wr)   wr_ptr_q <= wr_ptr_q + 1'b1;
        if (first_hit) found_q  <= 1'b1;
      end
      if (finish_go)         count_q <= res_count;
      if (finish_go)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept)    req_q    <= in_beat_i;
    if (mem_re)    rv_idx_q <= rd_ptr_q[IDX_W-1:0];
    if (first_hit) begin
      hit_q     <= rd_data_q;
      hit_idx_q <= rv_idx_q;
    end
    if (finish_go) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

[hdl/alt_checker.sv]
// Port-level checks for the address lease table, bound to the top level.
// Depends on alt_pkg; compiled after address_lease_table.
module alt_checker import alt_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input alt_out_t            out_beat_o
);

  localparam logic [COUNT_OUT_W-1:0] CAP_LO = COUNT_OUT_W'(CAPACITY);

  // one item at a time: an accepted beat blocks the next cycle
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted on two consecutive cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("stalled result changed or dropped");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CAPACITY > 63) || (out_beat_o.entry_count <= CAP_LO))
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.status == ST_FULL) |->
      out_beat_o.entry_count == CAP_LO)
    else $error("full status with table not full");

  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.status != ST_OK) |-> out_beat_o.value == '0)
    else $error("nonzero value on failed item");

endmodule

bind address_lease_table alt_checker #(.CAPACITY(CAPACITY)) u_alt_checker (.*);
